/* rtl/cpt_pkg.sv */
// Shared types for the closest-point-on-triangle pipeline.
// Used by cpt_divider and closest_point_on_triangle_unit; depends on nothing.
package cpt_pkg;

   // Which region of the triangle the query point falls into
   typedef enum logic [2:0] {
      RGN_A,
      RGN_B,
      RGN_C,
      RGN_AB,
      RGN_AC,
      RGN_BC,
      RGN_IN
   } region_type;

   // Forced result of a weight quotient, decided before the divide starts
   typedef enum logic [1:0] {
      CLAMP_NONE,
      CLAMP_ZERO,
      CLAMP_ONE
   } clamp_type;

   // Quotients formed side by side (edge weight, or both interior weights)
   localparam int N_LANES = 2;

endpackage

/* rtl/closest_point_on_triangle_unit.sv */
// Closest point on a triangle with barycentric weights, fixed point.
// Throughput: one word per cycle while the output is not stalled by rsp_tready;
// set by the fully pipelined multiply and divide stages.
// Reset clears only the stage valid bits; the pipeline is empty after reset.
// Depends on cpt_pkg, cpt_wide_mul and cpt_divider.
module closest_point_on_triangle_unit #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic clock,
   input  logic reset,
   // req_tdata, low bit up: point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
   // vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z, zero fill
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [((12*COORD_WIDTH+7)/8)*8-1:0]      req_tdata,
   // rsp_tdata, low bit up: near_x, near_y, near_z, weight_a, weight_b, weight_c, zero fill
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [((3*COORD_WIDTH+3*(FRAC_BITS+1)+7)/8)*8-1:0] rsp_tdata
);

   localparam int CW     = COORD_WIDTH;
   localparam int FB     = FRAC_BITS;
   localparam int DW     = CW + 1;
   localparam int DPW    = 2 * DW;
   localparam int PW     = 2 * DW + 2;
   localparam int VW     = 2 * PW + 3;
   localparam int PRW    = DW + FB + 2;
   localparam int SW     = CW + FB + 5;
   localparam int SHW    = SW - FB;
   localparam int OUT_W  = ((3*CW + 3*(FB+1) + 7) / 8) * 8;
   localparam int ST_DEC = 10;
   localparam int ST_Q   = 11 + FB;
   localparam int ST_OUT = ST_Q + 2;

   localparam logic [FB:0]            ONE    = {1'b1, {FB{1'b0}}};
   localparam logic signed [SHW-1:0]  SAT_HI = {{(SHW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [SHW-1:0]  SAT_LO = {{(SHW-CW+1){1'b1}}, {(CW-1){1'b0}}};

   typedef struct packed {
      logic [2:0][DW-1:0] bc;
      logic [2:0][DW-1:0] ac;
      logic [2:0][DW-1:0] ab;
      logic [2:0][CW-1:0] c;
      logic [2:0][CW-1:0] b;
      logic [2:0][CW-1:0] a;
   } carry_type;

   typedef struct packed {
      logic signed [PW-1:0] d1;
      logic signed [PW-1:0] d2;
      logic signed [PW:0]   lab;
      logic signed [PW:0]   lac;
      logic signed [PW:0]   e43;
      logic signed [PW:0]   e56;
      logic signed [PW+1:0] lbc;
      logic                 vtx_a;
      logic                 vtx_b;
      logic                 vtx_c;
      logic                 ab_ok;
      logic                 ac_ok;
      logic                 bc_pre;
      logic                 bc_ok;
   } side_type;

   logic en;
   logic vld_ff [1:ST_OUT];

   // ---------------------------------------------------------------- stage 1
   logic signed [CW-1:0] in_p [3], in_a [3], in_b [3], in_c [3];
   logic signed [DW-1:0] ab_ff [3], ac_ff [3], bc_ff [3];
   logic signed [DW-1:0] ap_ff [3], bp_ff [3], cp_ff [3];
   carry_type            car_in;
   carry_type            car_ff [1:ST_Q];

   // Global advance: move whenever the output word is free or being taken
   assign en         = !vld_ff[ST_OUT] || rsp_tready;
   assign req_tready = en;

   // Unpack the word and form edge and offset vectors
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         in_p[i] = req_tdata[i*CW +: CW];
         in_a[i] = req_tdata[(3+i)*CW +: CW];
         in_b[i] = req_tdata[(6+i)*CW +: CW];
         in_c[i] = req_tdata[(9+i)*CW +: CW];
         car_in.a[i]  = in_a[i];
         car_in.b[i]  = in_b[i];
         car_in.c[i]  = in_c[i];
         car_in.ab[i] = DW'(in_b[i]) - DW'(in_a[i]);
         car_in.ac[i] = DW'(in_c[i]) - DW'(in_a[i]);
         car_in.bc[i] = DW'(in_c[i]) - DW'(in_b[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            ab_ff[i] <= car_in.ab[i];
            ac_ff[i] <= car_in.ac[i];
            bc_ff[i] <= car_in.bc[i];
            ap_ff[i] <= DW'(in_p[i]) - DW'(in_a[i]);
            bp_ff[i] <= DW'(in_p[i]) - DW'(in_b[i]);
            cp_ff[i] <= DW'(in_p[i]) - DW'(in_c[i]);
         end
      end
   end

   // Hold vertices and edges alongside the arithmetic until the final blend
   always_ff @(posedge clock) begin
      if (en) begin
         car_ff[1] <= car_in;
         for (int k = 2; k <= ST_Q; k++) begin
            car_ff[k] <= car_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------- stage 2
   logic signed [DW-1:0]  opl [6][3], opr [6][3];
   logic signed [DPW-1:0] dp_ff [6][3];

   // Dot product operands: d1..d6 pair ab/ac with ap, bp, cp
   always_comb begin
      for (int j = 0; j < 6; j++) begin
         for (int i = 0; i < 3; i++) begin
            opl[j][i] = (j % 2 == 0) ? ab_ff[i] : ac_ff[i];
            opr[j][i] = (j < 2) ? ap_ff[i] : ((j < 4) ? bp_ff[i] : cp_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 6; j++) begin
            for (int i = 0; i < 3; i++) begin
               dp_ff[j][i] <= DPW'(opl[j][i]) * DPW'(opr[j][i]);
            end
         end
      end
   end

   // ---------------------------------------------------------------- stage 3
   logic signed [PW-1:0] d_ff [6];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 6; j++) begin
            d_ff[j] <= PW'(dp_ff[j][0]) + PW'(dp_ff[j][1]) + PW'(dp_ff[j][2]);
         end
      end
   end

   // ----------------------------------------------------- stages 4 to 6, cross terms
   logic signed [PW-1:0]   mul_x [6], mul_y [6];
   logic signed [2*PW-1:0] mul_p [6];

   // Products in order: d3*d6, d5*d4, d5*d2, d1*d6, d1*d4, d3*d2
   always_comb begin
      mul_x[0] = d_ff[2]; mul_y[0] = d_ff[5];
      mul_x[1] = d_ff[4]; mul_y[1] = d_ff[3];
      mul_x[2] = d_ff[4]; mul_y[2] = d_ff[1];
      mul_x[3] = d_ff[0]; mul_y[3] = d_ff[5];
      mul_x[4] = d_ff[0]; mul_y[4] = d_ff[3];
      mul_x[5] = d_ff[2]; mul_y[5] = d_ff[1];
   end

   for (genvar m = 0; m < 6; m++) begin : g_mul
      cpt_wide_mul #(
         .WIDTH (PW)
      ) u_mul (
         .clock (clock),
         .en    (en),
         .x     (mul_x[m]),
         .y     (mul_y[m]),
         .prod  (mul_p[m])
      );
   end

   // Region tests on the dot products, carried beside the multipliers
   side_type side_ff [4:ST_DEC-1];
   side_type s4_in, s5_in, s6_in;

   always_comb begin
      s4_in        = '0;
      s4_in.d1     = d_ff[0];
      s4_in.d2     = d_ff[1];
      s4_in.lab    = (PW+1)'(d_ff[0]) - (PW+1)'(d_ff[2]);
      s4_in.lac    = (PW+1)'(d_ff[1]) - (PW+1)'(d_ff[5]);
      s4_in.e43    = (PW+1)'(d_ff[3]) - (PW+1)'(d_ff[2]);
      s4_in.e56    = (PW+1)'(d_ff[4]) - (PW+1)'(d_ff[5]);
      s4_in.vtx_a  = (d_ff[0] <= 0) && (d_ff[1] <= 0);
      s4_in.vtx_b  = (d_ff[2] >= 0) && (s4_in.e43 <= 0);
      s4_in.vtx_c  = (d_ff[5] >= 0) && (s4_in.e56 <= 0);
      s4_in.ab_ok  = (d_ff[0] >= 0) && (d_ff[2] <= 0) && (s4_in.lab > 0);
      s4_in.ac_ok  = (d_ff[1] >= 0) && (d_ff[5] <= 0) && (s4_in.lac > 0);
      s4_in.bc_pre = (s4_in.e43 >= 0) && (s4_in.e56 >= 0);

      s5_in        = side_ff[4];
      s5_in.lbc    = (PW+2)'(side_ff[4].e43) + (PW+2)'(side_ff[4].e56);

      s6_in        = side_ff[5];
      s6_in.bc_ok  = side_ff[5].bc_pre && (side_ff[5].lbc > 0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[4] <= s4_in;
         side_ff[5] <= s5_in;
         side_ff[6] <= s6_in;
         for (int k = 7; k < ST_DEC; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------ stages 7 to 9, area terms
   logic signed [VW-1:0] va_ff, vb_ff, vc_ff;
   logic signed [VW-1:0] vab_ff, vb8_ff, vc8_ff, sum_ff, vb9_ff, vc9_ff;
   logic                 le0_a8_ff, le0_b8_ff, le0_c8_ff;
   logic                 le0_a9_ff, le0_b9_ff, le0_c9_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         va_ff <= VW'(mul_p[0]) - VW'(mul_p[1]);
         vb_ff <= VW'(mul_p[2]) - VW'(mul_p[3]);
         vc_ff <= VW'(mul_p[4]) - VW'(mul_p[5]);

         vab_ff    <= va_ff + vb_ff;
         vb8_ff    <= vb_ff;
         vc8_ff    <= vc_ff;
         le0_a8_ff <= (va_ff <= 0);
         le0_b8_ff <= (vb_ff <= 0);
         le0_c8_ff <= (vc_ff <= 0);

         sum_ff    <= vab_ff + vc8_ff;
         vb9_ff    <= vb8_ff;
         vc9_ff    <= vc8_ff;
         le0_a9_ff <= le0_a8_ff;
         le0_b9_ff <= le0_b8_ff;
         le0_c9_ff <= le0_c8_ff;
      end
   end

   // ------------------------------------------------------- stage 10, region pick
   cpt_pkg::region_type rgn_in;
   cpt_pkg::region_type rgn_ff [ST_DEC:ST_Q];
   logic signed [VW-1:0] num0_in, num1_in, den_in;
   logic signed [VW-1:0] num0_ff, num1_ff, den_ff;
   side_type             sd;

   always_comb begin
      sd      = side_ff[ST_DEC-1];
      rgn_in  = cpt_pkg::RGN_A;
      num0_in = '0;
      num1_in = '0;
      den_in  = VW'(1);
      priority if (sd.vtx_a) begin
         rgn_in = cpt_pkg::RGN_A;
      end else if (sd.vtx_b) begin
         rgn_in = cpt_pkg::RGN_B;
      end else if (sd.vtx_c) begin
         rgn_in = cpt_pkg::RGN_C;
      end else if (le0_c9_ff && sd.ab_ok) begin
         rgn_in  = cpt_pkg::RGN_AB;
         num0_in = VW'(sd.d1);
         den_in  = VW'(sd.lab);
      end else if (le0_b9_ff && sd.ac_ok) begin
         rgn_in  = cpt_pkg::RGN_AC;
         num0_in = VW'(sd.d2);
         den_in  = VW'(sd.lac);
      end else if (le0_a9_ff && sd.bc_ok) begin
         rgn_in  = cpt_pkg::RGN_BC;
         num0_in = VW'(sd.e43);
         den_in  = VW'(sd.lbc);
      end else if (sum_ff <= 0) begin
         // degenerate triangle falls back to vertex a
         rgn_in = cpt_pkg::RGN_A;
      end else begin
         rgn_in  = cpt_pkg::RGN_IN;
         num0_in = vb9_ff;
         num1_in = vc9_ff;
         den_in  = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rgn_ff[ST_DEC] <= rgn_in;
         for (int k = ST_DEC + 1; k <= ST_Q; k++) begin
            rgn_ff[k] <= rgn_ff[k-1];
         end
         num0_ff <= num0_in;
         num1_ff <= num1_in;
         den_ff  <= den_in;
      end
   end

   // ------------------------------------------------------- stage 11, clamp decision
   cpt_pkg::clamp_type clamp_ff [cpt_pkg::N_LANES];
   logic [VW-1:0]      dnum_ff  [cpt_pkg::N_LANES];
   logic [VW-1:0]      dden_ff;
   logic [FB:0]        quo      [cpt_pkg::N_LANES];

   always_ff @(posedge clock) begin
      if (en) begin
         clamp_ff[0] <= (num0_ff <= 0) ? cpt_pkg::CLAMP_ZERO :
                        ((num0_ff >= den_ff) ? cpt_pkg::CLAMP_ONE : cpt_pkg::CLAMP_NONE);
         clamp_ff[1] <= (num1_ff <= 0) ? cpt_pkg::CLAMP_ZERO :
                        ((num1_ff >= den_ff) ? cpt_pkg::CLAMP_ONE : cpt_pkg::CLAMP_NONE);
         dnum_ff[0]  <= num0_ff;
         dnum_ff[1]  <= num1_ff;
         dden_ff     <= den_ff;
      end
   end

   // ------------------------------------------------- stages 12 to ST_Q, quotients
   cpt_divider #(
      .VW        (VW),
      .FRAC_BITS (FB)
   ) u_div (
      .clock (clock),
      .en    (en),
      .num   (dnum_ff),
      .den   (dden_ff),
      .clamp (clamp_ff),
      .quo   (quo)
   );

   // --------------------------------------------------- stage ST_Q+1, edge products
   carry_type            cq;
   logic signed [CW-1:0] base_in [3];
   logic signed [DW-1:0] e1_in [3], e2_in [3];
   logic [FB:0]          v_in, w_in, wa_in, wb_in, wc_in;
   logic [FB+1:0]        vw_sum;
   logic signed [CW-1:0] base_ff [3];
   logic signed [PRW-1:0] p1_ff [3], p2_ff [3];
   logic [FB:0]          wa_ff, wb_ff, wc_ff;

   always_comb begin
      cq     = car_ff[ST_Q];
      v_in   = '0;
      w_in   = '0;
      wa_in  = '0;
      wb_in  = '0;
      wc_in  = '0;
      vw_sum = (FB+2)'(quo[0]) + (FB+2)'(quo[1]);
      for (int i = 0; i < 3; i++) begin
         base_in[i] = cq.a[i];
         e1_in[i]   = '0;
         e2_in[i]   = '0;
      end
      unique case (rgn_ff[ST_Q])
         cpt_pkg::RGN_A: begin
            wa_in = ONE;
         end
         cpt_pkg::RGN_B: begin
            for (int i = 0; i < 3; i++) base_in[i] = cq.b[i];
            wb_in = ONE;
         end
         cpt_pkg::RGN_C: begin
            for (int i = 0; i < 3; i++) base_in[i] = cq.c[i];
            wc_in = ONE;
         end
         cpt_pkg::RGN_AB: begin
            for (int i = 0; i < 3; i++) e1_in[i] = cq.ab[i];
            v_in  = quo[0];
            wa_in = ONE - quo[0];
            wb_in = quo[0];
         end
         cpt_pkg::RGN_AC: begin
            for (int i = 0; i < 3; i++) e1_in[i] = cq.ac[i];
            v_in  = quo[0];
            wa_in = ONE - quo[0];
            wc_in = quo[0];
         end
         cpt_pkg::RGN_BC: begin
            for (int i = 0; i < 3; i++) begin
               base_in[i] = cq.b[i];
               e1_in[i]   = cq.bc[i];
            end
            v_in  = quo[0];
            wb_in = ONE - quo[0];
            wc_in = quo[0];
         end
         cpt_pkg::RGN_IN: begin
            for (int i = 0; i < 3; i++) begin
               e1_in[i] = cq.ab[i];
               e2_in[i] = cq.ac[i];
            end
            v_in  = quo[0];
            w_in  = quo[1];
            wa_in = (vw_sum >= (FB+2)'(ONE)) ? '0 : (FB+1)'((FB+2)'(ONE) - vw_sum);
            wb_in = quo[0];
            wc_in = quo[1];
         end
         default: begin
            wa_in = ONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            base_ff[i] <= base_in[i];
            p1_ff[i]   <= PRW'(e1_in[i]) * PRW'($signed({1'b0, v_in}));
            p2_ff[i]   <= PRW'(e2_in[i]) * PRW'($signed({1'b0, w_in}));
         end
         wa_ff <= wa_in;
         wb_ff <= wb_in;
         wc_ff <= wc_in;
      end
   end

   // ------------------------------------------------ stage ST_OUT, blend and saturate
   logic signed [SW-1:0]  blend [3];
   logic signed [SHW-1:0] shr [3];
   logic signed [CW-1:0]  near_in [3];
   logic signed [CW-1:0]  near_ff [3];
   logic [FB:0]           owa_ff, owb_ff, owc_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         blend[i] = (SW'(base_ff[i]) <<< FB) + SW'(p1_ff[i]) + SW'(p2_ff[i]);
         shr[i]   = SHW'(blend[i] >>> FB);
         if (shr[i] > SAT_HI) begin
            near_in[i] = CW'(SAT_HI);
         end else if (shr[i] < SAT_LO) begin
            near_in[i] = CW'(SAT_LO);
         end else begin
            near_in[i] = CW'(shr[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) near_ff[i] <= near_in[i];
         owa_ff <= wa_ff;
         owb_ff <= wb_ff;
         owc_ff <= wc_ff;
      end
   end

   // Advance valid bits with the data; drop nothing on a stall
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= ST_OUT; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[1] <= req_tvalid;
         for (int k = 2; k <= ST_OUT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   assign rsp_tvalid = vld_ff[ST_OUT];
   assign rsp_tdata  = OUT_W'({owc_ff, owb_ff, owa_ff, near_ff[2], near_ff[1], near_ff[0]});

endmodule

/* rtl/cpt_wide_mul.sv */
// Pipelined signed multiplier for wide operands, split into four partial products.
// Advances on en. Depends on no package.
module cpt_wide_mul #(
   parameter int WIDTH = 68
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [WIDTH-1:0]   x,
   input  logic signed [WIDTH-1:0]   y,
   output logic signed [2*WIDTH-1:0] prod
);

   localparam int LO   = (WIDTH + 1) / 2;
   localparam int HI   = WIDTH - LO;
   localparam int MIDW = WIDTH + 2;

   logic signed [HI-1:0]      x_hi, y_hi;
   logic signed [LO:0]        x_lo, y_lo;
   logic signed [2*HI-1:0]    hh_ff;
   logic signed [WIDTH:0]     hl_ff, lh_ff;
   logic [2*LO-1:0]           ll_ff;
   logic signed [2*WIDTH-1:0] hhll_ff;
   logic signed [MIDW-1:0]    mid_ff;
   logic signed [2*WIDTH-1:0] prod_ff;

   // Split each operand into a signed upper half and an unsigned lower half
   assign x_hi = x[WIDTH-1:LO];
   assign y_hi = y[WIDTH-1:LO];
   assign x_lo = {1'b0, x[LO-1:0]};
   assign y_lo = {1'b0, y[LO-1:0]};

   // Form the partial products
   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff <= (2*HI)'(x_hi) * (2*HI)'(y_hi);
         hl_ff <= (WIDTH+1)'(x_hi) * (WIDTH+1)'(y_lo);
         lh_ff <= (WIDTH+1)'(x_lo) * (WIDTH+1)'(y_hi);
         ll_ff <= (2*LO)'(x[LO-1:0]) * (2*LO)'(y[LO-1:0]);
      end
   end

   // Join outer terms by placement, add the cross terms
   always_ff @(posedge clock) begin
      if (en) begin
         hhll_ff <= {hh_ff, ll_ff};
         mid_ff  <= MIDW'(hl_ff) + MIDW'(lh_ff);
      end
   end

   // Final accumulate
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= hhll_ff + ((2*WIDTH)'(mid_ff) <<< LO);
      end
   end

   assign prod = prod_ff;

endmodule

/* rtl/cpt_divider.sv */
// Two-lane pipelined restoring divider producing FRAC_BITS-bit fractional quotients.
// One quotient bit per stage, shared divisor. Depends on cpt_pkg.
module cpt_divider #(
   parameter int VW        = 139,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [VW-1:0]        num   [cpt_pkg::N_LANES],
   input  logic [VW-1:0]        den,
   input  cpt_pkg::clamp_type   clamp [cpt_pkg::N_LANES],
   output logic [FRAC_BITS:0]   quo   [cpt_pkg::N_LANES]
);

   localparam int FB = FRAC_BITS;
   localparam int NL = cpt_pkg::N_LANES;

   logic [VW-1:0]      rem_ff [FB][NL];
   logic [VW-1:0]      rem_in [FB][NL];
   logic [FB-1:0]      quo_ff [FB][NL];
   logic [FB-1:0]      quo_in [FB][NL];
   logic [VW-1:0]      den_ff [FB];
   logic [VW-1:0]      den_in [FB];
   cpt_pkg::clamp_type clp_ff [FB][NL];
   cpt_pkg::clamp_type clp_in [FB][NL];

   // One restoring step per stage: double the remainder, subtract if it fits
   always_comb begin
      logic [VW-1:0]      src_rem;
      logic [FB-1:0]      src_quo;
      logic [VW-1:0]      src_den;
      logic [VW+1:0]      trial;
      for (int s = 0; s < FB; s++) begin
         src_den   = (s == 0) ? den : den_ff[(s == 0) ? 0 : s-1];
         den_in[s] = src_den;
         for (int l = 0; l < NL; l++) begin
            if (s == 0) begin
               src_rem   = num[l];
               src_quo   = '0;
               clp_in[s][l] = clamp[l];
            end else begin
               src_rem   = rem_ff[s-1][l];
               src_quo   = quo_ff[s-1][l];
               clp_in[s][l] = clp_ff[s-1][l];
            end
            trial = {1'b0, src_rem, 1'b0} - {2'b00, src_den};
            if (trial[VW+1]) begin
               rem_in[s][l] = {src_rem[VW-2:0], 1'b0};
            end else begin
               rem_in[s][l] = trial[VW-1:0];
            end
            quo_in[s][l] = {src_quo[FB-2:0], ~trial[VW+1]};
         end
      end
   end

   // Advance all stages together
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         den_ff <= den_in;
         clp_ff <= clp_in;
      end
   end

   // Apply the clamp decided up front
   always_comb begin
      for (int l = 0; l < NL; l++) begin
         unique case (clp_ff[FB-1][l])
            cpt_pkg::CLAMP_ZERO: quo[l] = '0;
            cpt_pkg::CLAMP_ONE:  quo[l] = {1'b1, {FB{1'b0}}};
            cpt_pkg::CLAMP_NONE: quo[l] = {1'b0, quo_ff[FB-1][l]};
            default:             quo[l] = '0;
         endcase
      end
   end

endmodule
